/* sv/fae_pkg.sv */
// Shared types and constants of the frame allocator with oldest-load eviction.
package fae_pkg;

    typedef logic [1:0] t_op;
    localparam t_op OP_GET    = 2'd0;
    localparam t_op OP_FREE   = 2'd1;
    localparam t_op OP_SHARE  = 2'd2;
    localparam t_op OP_UNSHARE = 2'd3;

    typedef enum logic [2:0] {
        KIND_GRANT    = 3'd0,
        KIND_NONE     = 3'd1,
        KIND_PAGEOUT  = 3'd2,
        KIND_WRITABLE = 3'd3,
        KIND_ACK      = 3'd4
    } t_kind;

    typedef struct packed {
        t_op        op;
        logic [3:0] requester_pid;
        logic [4:0] frame;
        logic       skip_valid;
    } t_req;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] frame_out;
        logic [3:0] target_pid;
        logic [5:0] free_count;
        logic       last;
    } t_res;

    typedef struct packed {
        logic  load;
        logic  clr;
        logic  scan_start;
        logic  scan;
        logic  take_free;
        logic  take_cand;
        logic  free_set;
        logic  own_load;
        logic  own_step;
        logic  grant;
        logic  add_wr;
        logic  rem_wr;
        logic  emit;
        t_kind emit_kind;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic free_found;
        logic cand_found;
        logic evict;
        logic fr_ok;
        t_op  op;
        logic pid_done;
        logic own_bit;
        logic one_owner;
        logic out_free;
    } t_status;

endpackage

/* sv/fae_if.sv */
// Request and result channel interfaces.
interface fae_req_if;
    logic          valid;
    logic          ready;
    fae_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fae_res_if;
    logic          valid;
    logic          ready;
    fae_pkg::t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/fae_ram.sv */
// Generic simple dual-port RAM with registered read.
module fae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/fae_ctrl.sv */
// Sequencer of the frame allocator.
module fae_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fae_pkg::t_status i_sts,
    output fae_pkg::t_cmd    o_cmd
);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_SCAN, ST_DECIDE, ST_OWN_RD, ST_OWN_LD,
        ST_PAGEOUT, ST_GRANT, ST_ADD, ST_REM, ST_COUNT, ST_REM_END, ST_ACK, ST_NONE
    } t_state;

    t_state        r_state;
    t_state        n_state;
    fae_pkg::t_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        n_cmd.emit_kind = fae_pkg::KIND_ACK;
        case (r_state)
            ST_CLEAR: begin
                n_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.load = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_sts.op)
                    fae_pkg::OP_GET: begin
                        n_cmd.scan_start = 1'b1;
                        n_state = ST_SCAN;
                    end
                    fae_pkg::OP_FREE: begin
                        n_cmd.free_set = i_sts.fr_ok;
                        n_state = ST_ACK;
                    end
                    default: begin
                        n_state = i_sts.fr_ok ? ST_OWN_RD : ST_ACK;
                    end
                endcase
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_cmd.scan = 1'b1;
                end
            end
            ST_DECIDE: begin
                if (i_sts.free_found) begin
                    n_cmd.take_free = 1'b1;
                    n_state = ST_OWN_RD;
                end else if (i_sts.cand_found) begin
                    n_cmd.take_cand = 1'b1;
                    n_state = ST_OWN_RD;
                end else begin
                    n_state = ST_NONE;
                end
            end
            ST_OWN_RD: begin
                n_state = ST_OWN_LD;
            end
            ST_OWN_LD: begin
                n_cmd.own_load = 1'b1;
                case (i_sts.op)
                    fae_pkg::OP_GET:   n_state = i_sts.evict ? ST_PAGEOUT : ST_GRANT;
                    fae_pkg::OP_SHARE: n_state = ST_ADD;
                    default:           n_state = ST_REM;
                endcase
            end
            ST_PAGEOUT: begin
                if (i_sts.pid_done) begin
                    n_state = ST_GRANT;
                end else if (!i_sts.own_bit || i_sts.out_free) begin
                    n_cmd.own_step  = 1'b1;
                    n_cmd.emit      = i_sts.own_bit;
                    n_cmd.emit_kind = fae_pkg::KIND_PAGEOUT;
                end
            end
            ST_GRANT: begin
                if (i_sts.out_free) begin
                    n_cmd.grant     = 1'b1;
                    n_cmd.emit      = 1'b1;
                    n_cmd.emit_kind = fae_pkg::KIND_GRANT;
                    n_state = ST_IDLE;
                end
            end
            ST_ADD: begin
                if (i_sts.out_free) begin
                    n_cmd.add_wr = 1'b1;
                    n_cmd.emit   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_REM: begin
                n_cmd.rem_wr = 1'b1;
                n_state = ST_COUNT;
            end
            ST_COUNT: begin
                if (i_sts.pid_done) begin
                    n_state = ST_REM_END;
                end else begin
                    n_cmd.own_step = 1'b1;
                end
            end
            ST_REM_END: begin
                if (!i_sts.one_owner) begin
                    n_state = ST_ACK;
                end else if (i_sts.out_free) begin
                    n_cmd.emit      = 1'b1;
                    n_cmd.emit_kind = fae_pkg::KIND_WRITABLE;
                    n_state = ST_ACK;
                end
            end
            ST_ACK: begin
                if (i_sts.out_free) begin
                    n_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_NONE: begin
                if (i_sts.out_free) begin
                    n_cmd.emit      = 1'b1;
                    n_cmd.emit_kind = fae_pkg::KIND_NONE;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd      = n_cmd;
endmodule

/* sv/fae_dp.sv */
// Datapath of the frame allocator: free map, stamp and owner stores, scan and result register.
module fae_dp #(
    parameter int NUM_FRAMES = 32,
    parameter int MAX_PROCS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fae_pkg::t_req    i_req,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output fae_pkg::t_res    o_out,
    input  fae_pkg::t_cmd    i_cmd,
    output fae_pkg::t_status o_sts
);
    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int IW  = FW + 1;
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int PW  = $clog2(MAX_PROCS);
    localparam int PIW = PW + 1;

    fae_pkg::t_op      r_op;
    logic [3:0]        r_pid;
    logic [4:0]        r_fr;
    logic              r_skip;
    logic [NUM_FRAMES-1:0] r_free_map;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_idx;
    logic              r_ev_valid;
    logic [FW-1:0]     r_ev_idx;
    logic              r_free_found;
    logic [FW-1:0]     r_free_pick;
    logic              r_cand_found;
    logic [FW-1:0]     r_cand;
    logic [31:0]       r_best;
    logic [FW-1:0]     r_tgt;
    logic              r_evict;
    logic [31:0]       r_stamp_ctr;
    logic [MAX_PROCS-1:0] r_own;
    logic [PIW-1:0]    r_pidx;
    logic [1:0]        r_cnt;
    logic [PW-1:0]     r_only;
    logic              r_out_valid;
    fae_pkg::t_res     r_out;

    logic [31:0]          stamp_rdata;
    logic [MAX_PROCS-1:0] own_rdata;
    logic [MAX_PROCS-1:0] pid_bit;
    logic [FW-1:0]        fr_idx;
    logic [FW-1:0]        waddr;
    logic                 stamp_we;
    logic [31:0]          stamp_wdata;
    logic                 own_we;
    logic [MAX_PROCS-1:0] own_wdata;
    logic                 skipped;
    logic                 out_free;
    logic                 cur_bit;
    fae_pkg::t_res        n_out;

    always_comb begin
        for (int j = 0; j < MAX_PROCS; j++) begin
            pid_bit[j] = (32'(j) == 32'(r_pid));
        end
    end

    assign fr_idx   = FW'(r_fr);
    assign waddr    = i_cmd.clr ? r_idx[FW-1:0] : r_tgt;
    assign stamp_we = i_cmd.clr | i_cmd.grant;
    assign stamp_wdata = i_cmd.clr ? 32'hFFFF_FFFF : r_stamp_ctr;
    assign own_we   = i_cmd.clr | i_cmd.grant | i_cmd.add_wr | i_cmd.rem_wr;
    assign skipped  = r_skip && (32'(r_ev_idx) == 32'(r_fr));
    assign out_free = !r_out_valid || i_out_ready;
    assign cur_bit  = r_own[r_pidx[PW-1:0]];

    always_comb begin
        if (i_cmd.clr) begin
            own_wdata = '0;
        end else if (i_cmd.rem_wr) begin
            own_wdata = r_own & ~pid_bit;
        end else if (i_cmd.grant && r_evict) begin
            own_wdata = pid_bit;
        end else begin
            own_wdata = r_own | pid_bit;
        end
    end

    fae_ram #(.WIDTH(32), .DEPTH(NUM_FRAMES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (waddr),
        .i_wdata (stamp_wdata),
        .i_raddr (r_idx[FW-1:0]),
        .o_rdata (stamp_rdata)
    );

    fae_ram #(.WIDTH(MAX_PROCS), .DEPTH(NUM_FRAMES)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (waddr),
        .i_wdata (own_wdata),
        .i_raddr (r_tgt),
        .o_rdata (own_rdata)
    );

    always_comb begin
        n_out.kind       = i_cmd.emit_kind;
        n_out.free_count = 6'(r_count);
        n_out.last       = 1'b1;
        case (i_cmd.emit_kind)
            fae_pkg::KIND_GRANT: begin
                n_out.frame_out  = 5'(r_tgt);
                n_out.target_pid = r_pid;
            end
            fae_pkg::KIND_NONE: begin
                n_out.frame_out  = '0;
                n_out.target_pid = '0;
            end
            fae_pkg::KIND_PAGEOUT: begin
                n_out.frame_out  = 5'(r_tgt);
                n_out.target_pid = 4'(r_pidx[PW-1:0]);
                n_out.last       = 1'b0;
            end
            fae_pkg::KIND_WRITABLE: begin
                n_out.frame_out  = r_fr;
                n_out.target_pid = 4'(r_only);
                n_out.last       = 1'b0;
            end
            default: begin
                n_out.frame_out  = r_fr;
                n_out.target_pid = r_pid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map   <= '1;
            r_count      <= CW'(NUM_FRAMES);
            r_idx        <= '0;
            r_ev_valid   <= 1'b0;
            r_stamp_ctr  <= '0;
            r_out_valid  <= 1'b0;
            r_free_found <= 1'b0;
            r_cand_found <= 1'b0;
            r_evict      <= 1'b0;
        end else begin
            r_ev_valid <= i_cmd.scan;
            if (i_cmd.clr || i_cmd.scan) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.scan) begin
                r_ev_idx <= r_idx[FW-1:0];
            end
            if (i_cmd.load) begin
                r_op    <= i_req.op;
                r_pid   <= i_req.requester_pid;
                r_fr    <= i_req.frame;
                r_skip  <= i_req.skip_valid;
                r_tgt   <= FW'(i_req.frame);
                r_evict <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_idx        <= '0;
                r_free_found <= 1'b0;
                r_cand_found <= 1'b0;
            end
            if (r_ev_valid) begin
                if (r_free_map[r_ev_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_pick  <= r_ev_idx;
                end
                if (!skipped && (!r_cand_found || $signed(stamp_rdata) < $signed(r_best))) begin
                    r_cand_found <= 1'b1;
                    r_cand       <= r_ev_idx;
                    r_best       <= stamp_rdata;
                end
            end
            if (i_cmd.take_free) begin
                r_tgt <= r_free_pick;
                r_free_map[r_free_pick] <= 1'b0;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.take_cand) begin
                r_tgt   <= r_cand;
                r_evict <= 1'b1;
            end
            if (i_cmd.free_set) begin
                r_free_map[fr_idx] <= 1'b1;
                if (!r_free_map[fr_idx]) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.own_load || i_cmd.rem_wr) begin
                r_own  <= i_cmd.rem_wr ? (r_own & ~pid_bit) : own_rdata;
                r_pidx <= '0;
                r_cnt  <= '0;
            end
            if (i_cmd.own_step) begin
                r_pidx <= r_pidx + 1'b1;
                if (cur_bit) begin
                    r_only <= r_pidx[PW-1:0];
                    if (r_cnt != 2'd2) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
            if (i_cmd.grant) begin
                r_stamp_ctr <= r_stamp_ctr + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last   = (r_idx[FW-1:0] == FW'(NUM_FRAMES - 1));
    assign o_sts.scan_done  = (r_idx == IW'(NUM_FRAMES));
    assign o_sts.free_found = r_free_found;
    assign o_sts.cand_found = r_cand_found;
    assign o_sts.evict      = r_evict;
    assign o_sts.fr_ok      = (32'(r_fr) < NUM_FRAMES);
    assign o_sts.op         = r_op;
    assign o_sts.pid_done   = (r_pidx == PIW'(MAX_PROCS));
    assign o_sts.own_bit    = cur_bit;
    assign o_sts.one_owner  = (r_cnt == 2'd1);
    assign o_sts.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

/* sv/frame_allocator_fifo_evict_unit.sv */
// Top level of the frame allocator with oldest-load eviction.
// Channels: i_req takes one request (op, requester pid, frame, skip flag);
// o_res gives its results one by one, the final one marked by last.
// Requests: get, free, add sharer, remove sharer. A get takes the lowest free
// frame, or evicts the oldest-stamped frame and sends a page-out result to
// each of its owners before the grant. Remove sharer may send a make-writable
// result before its acknowledge. Every result carries the free frame count.
// A get scans the stamps one frame a cycle through the stamp RAM read port, and
// walks the owners when it evicts. Remove sharer counts the owners of the frame,
// walking one pid a cycle.
// One request is in work at a time; i_req.ready is high only when idle.
// Reset: a clearing pass writes every stamp and owner entry; i_req.ready stays
// low until it ends. All frames start free.
// Stall: the result register holds while o_res.ready is low and the sequencer
// waits; a request is still accepted while a final result waits.
module frame_allocator_fifo_evict_unit #(
    parameter int NUM_FRAMES = 32,
    parameter int MAX_PROCS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fae_req_if.sink   i_req,
    fae_res_if.source o_res
);
    fae_pkg::t_cmd    cmd;
    fae_pkg::t_status sts;
    logic             in_ready;

    fae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fae_dp #(.NUM_FRAMES(NUM_FRAMES), .MAX_PROCS(MAX_PROCS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req.payload),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out       (o_res.payload),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign i_req.ready = in_ready;

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result written over a waiting result");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !cmd.emit)
        else $error("result issued right after accept");

    a_grant_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.grant |-> (sts.free_found || sts.cand_found))
        else $error("grant without a chosen frame");
endmodule

/* sim/tb_frame_allocator_fifo_evict_unit.sv */
// Self-checking testbench of the frame allocator with oldest-load eviction.
`timescale 1ns / 100ps

module tb_frame_allocator_fifo_evict_unit;

    localparam int NFR = 32;
    localparam int NPID = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    class frame_alloc_scoreboard;
        bit             free_map[NFR];
        bit [31:0]      load_stamp[NFR];
        bit [31:0]      stamp_ctr;
        bit [NPID-1:0]  owners[NFR];
        fae_pkg::t_res  pending[$];
        int             errors;

        function new();
            for (int i = 0; i < NFR; i++) begin
                free_map[i] = 1'b1;
                load_stamp[i] = 32'hFFFF_FFFF;
                owners[i] = '0;
            end
            stamp_ctr = '0;
            errors = 0;
        endfunction

        function bit all_busy();
            foreach (free_map[i]) if (free_map[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void push(fae_pkg::t_kind k, int fr, int pid, bit lst);
            fae_pkg::t_res r;
            int n;
            n = 0;
            foreach (free_map[i]) n += free_map[i];
            r.kind = k;
            r.frame_out = fr[4:0];
            r.target_pid = pid[3:0];
            r.free_count = n[5:0];
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_request(fae_pkg::t_req q);
            int pick;
            int cnt;
            int only;
            bit found;
            bit [31:0] best;
            bit [31:0] key;
            pick = 0;
            found = 1'b0;
            best = '0;
            cnt = 0;
            only = 0;
            if (q.op == fae_pkg::OP_GET) begin
                for (int i = 0; i < NFR; i++) begin
                    if (!found && free_map[i]) begin
                        pick = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    free_map[pick] = 1'b0;
                end else begin
                    for (int i = 0; i < NFR; i++) begin
                        if (q.skip_valid && i == q.frame) continue;
                        key = load_stamp[i] ^ 32'h8000_0000;
                        if (!found || key < best) begin
                            best = key;
                            pick = i;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        push(fae_pkg::KIND_NONE, 0, 0, 1'b1);
                        return;
                    end
                    for (int p = 0; p < NPID; p++) begin
                        if (owners[pick][p]) begin
                            owners[pick][p] = 1'b0;
                            push(fae_pkg::KIND_PAGEOUT, pick, p, 1'b0);
                        end
                    end
                end
                load_stamp[pick] = stamp_ctr;
                stamp_ctr++;
                owners[pick][q.requester_pid] = 1'b1;
                push(fae_pkg::KIND_GRANT, pick, q.requester_pid, 1'b1);
                return;
            end
            if (q.op == fae_pkg::OP_FREE) begin
                free_map[q.frame] = 1'b1;
            end else if (q.op == fae_pkg::OP_SHARE) begin
                owners[q.frame][q.requester_pid] = 1'b1;
            end else begin
                owners[q.frame][q.requester_pid] = 1'b0;
                for (int p = 0; p < NPID; p++) begin
                    if (owners[q.frame][p]) begin
                        only = p;
                        cnt++;
                    end
                end
                if (cnt == 1) push(fae_pkg::KIND_WRITABLE, q.frame, only, 1'b0);
            end
            push(fae_pkg::KIND_ACK, q.frame, q.requester_pid, 1'b1);
        endfunction

        function void check_result(fae_pkg::t_res a);
            fae_pkg::t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind || a.frame_out !== e.frame_out
                    || a.target_pid !== e.target_pid || a.free_count !== e.free_count
                    || a.last !== e.last) begin
                $display("%0t: mismatch expected %p actual %p", $time, e, a);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    fae_req_if req_ch();
    fae_res_if res_ch();

    frame_allocator_fifo_evict_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    frame_alloc_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.payload);
            if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.payload);
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(fae_pkg::t_op op, int pid, int fr, bit skp);
        fae_pkg::t_req q;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        q.op = op;
        q.requester_pid = pid[3:0];
        q.frame = fr[4:0];
        q.skip_valid = skp;
        req_ch.valid <= 1'b1;
        req_ch.payload <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_request(fae_pkg::OP_GET, $urandom_range(15), $urandom_range(31),
                         $urandom_range(1));
        else if (r < 60)
            send_request(fae_pkg::OP_FREE, $urandom_range(15), $urandom_range(31),
                         $urandom_range(1));
        else if (r < 82)
            send_request(fae_pkg::OP_SHARE, $urandom_range(15), $urandom_range(31),
                         $urandom_range(1));
        else
            send_request(fae_pkg::OP_UNSHARE, $urandom_range(15), $urandom_range(31),
                         $urandom_range(1));
    endtask

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles = 0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 78;
        send_request(fae_pkg::OP_GET, 15, 31, 1'b0);
        send_request(fae_pkg::OP_SHARE, 3, 0, 1'b0);
        send_request(fae_pkg::OP_SHARE, 0, 0, 1'b0);
        send_request(fae_pkg::OP_UNSHARE, 3, 0, 1'b0);
        send_request(fae_pkg::OP_UNSHARE, 0, 0, 1'b1);
        send_request(fae_pkg::OP_FREE, 0, 0, 1'b0);
        send_request(fae_pkg::OP_SHARE, 9, 31, 1'b0);
        send_request(fae_pkg::OP_FREE, 9, 31, 1'b0);
        // fill every frame, then force evictions
        for (int i = 0; i < 33; i++) send_request(fae_pkg::OP_GET, i % 16, 0, 1'b0);
        for (int p = 0; p < 16; p++) send_request(fae_pkg::OP_SHARE, p, 1, 1'b0);
        send_request(fae_pkg::OP_GET, 4, 1, 1'b1);
        send_request(fae_pkg::OP_GET, 5, 0, 1'b1);
        send_request(fae_pkg::OP_GET, 6, 31, 1'b1);

        for (int i = 0; i < 190; i++) begin
            if (i == 25) begin
                send_idle_pct = 78;
                recv_idle_pct = 6;
            end else if (i == 108) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i % 40 == 0 && sb.all_busy())
                for (int k = 0; k < 4; k++)
                    send_request(fae_pkg::OP_FREE, $urandom_range(15), $urandom_range(31),
                                 1'b0);
            send_random();
        end
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* files.f */
sv/fae_pkg.sv
sv/fae_if.sv
sv/fae_ram.sv
sv/fae_ctrl.sv
sv/fae_dp.sv
sv/frame_allocator_fifo_evict_unit.sv
sim/tb_frame_allocator_fifo_evict_unit.sv
